// ----- hdl/wbf_pkg.sv -----
`default_nettype none

package wbf_pkg;

	localparam int MaxWidthDef  = 1024;
	localparam int MaxRadiusDef = 3;
	localparam int CoefBitsDef  = 16;
	localparam int RomRadii     = 3;
	localparam int RomSide      = 7;
	localparam int FrameRowsMax = 4096;
	localparam int PixW         = 16;
	localparam int OutXW        = 10;
	localparam int OutYW        = 12;
	localparam int CfgIdxW      = 2;
	localparam int CfgDataW     = 13;

	typedef enum logic [CfgIdxW-1:0] {
		REG_BLUR_MODE     = 2'd0,
		REG_KERNEL_RADIUS = 2'd1,
		REG_IMAGE_WIDTH   = 2'd2,
		REG_IMAGE_HEIGHT  = 2'd3
	} cfg_reg_t;

	// exp(-1/R) in Q0.32 for R = 1..3
	localparam logic [31:0] GaussStepQ32 [RomRadii] = '{
		32'd1580030168, 32'd2605029347, 32'd3077478546
	};

	// control handed to every column cell
	typedef struct packed {
		logic shift;
		logic take_new;
		logic take_nb;
	} cell_ctrl_t;

	// long division by shift and subtract, evaluated at elaboration only
	function automatic logic [127:0] udiv_f(input logic [127:0] a, input logic [127:0] b);
		logic [127:0] q;
		logic [127:0] rem;
		int t;
		q   = '0;
		rem = '0;
		for (t = 127; t >= 0; t--) begin
			rem = {rem[126:0], a[t]};
			if (rem >= b) begin
				rem  = rem - b;
				q[t] = 1'b1;
			end
		end
		return q;
	endfunction

	// kernel coefficient, evaluated at elaboration only
	function automatic logic [31:0] coef_f(input int mode, input int r, input int k,
			input int cb);
		logic [127:0] p;
		logic [127:0] sum;
		logic [127:0] wk;
		logic [127:0] g;
		logic [127:0] n;
		int side;
		int di;
		int dj;
		int d;
		int ii;
		int jj;
		int t;
		side = 2 * r + 1;
		n    = 128'(side * side);
		g    = 128'(GaussStepQ32[r-1]);
		sum  = '0;
		wk   = '0;
		for (ii = 0; ii < side; ii++) begin
			for (jj = 0; jj < side; jj++) begin
				di = ii - r;
				dj = jj - r;
				d  = di * di + dj * dj;
				p  = 128'd1 << 32;
				for (t = 0; t < d; t++) begin
					p = (p * g + (128'd1 << 31)) >> 32;
				end
				sum = sum + p;
				if (ii * RomSide + jj == k) begin
					wk = p;
				end
			end
		end
		if (mode == 0) begin
			return 32'(udiv_f((128'd1 << cb) + (n >> 1), n));
		end
		return 32'(udiv_f((wk << cb) + (sum >> 1), sum));
	endfunction

endpackage

`default_nettype wire

// ----- hdl/wbf_ram.sv -----
`default_nettype none

module wbf_ram #(
	parameter int DW    = 16,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [DW-1:0]            wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [DW-1:0]            rdata
);

	logic [DW-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ----- hdl/wbf_col_cell.sv -----
`default_nettype none

module wbf_col_cell import wbf_pkg::*; #(
	parameter int WIN = 7
) (
	input  wire logic                    clk,
	input  wire cell_ctrl_t              ctrl,
	input  wire logic [WIN-1:0]          row_en,
	input  wire logic [PixW-1:0]         nb_col [WIN],
	input  wire logic [PixW-1:0]         new_col [WIN],
	input  wire logic [$clog2(WIN)-1:0]  sel,
	output logic      [PixW-1:0]         col_q [WIN],
	output logic      [PixW-1:0]         sel_pix
);

	// one window column; rows outside the kernel keep their contents
	always_ff @(posedge clk) begin
		for (int j = 0; j < WIN; j++) begin
			if (ctrl.shift && row_en[j]) begin
				if (ctrl.take_new) begin
					col_q[j] <= new_col[j];
				end else if (ctrl.take_nb) begin
					col_q[j] <= nb_col[j];
				end
			end
		end
	end

	assign sel_pix = col_q[sel];

endmodule

`default_nettype wire

// ----- hdl/window_blur_filter_core.sv -----
// channel  | direction | handshake                  | payload
// pixel    | in        | pixel_valid / pixel_stall  | pixel_value
// result   | out       | result_valid / result_stall| out_x, out_y, out_value, last_of_item
// config   | in        | cfg_we                     | cfg_index, cfg_data
//
// one word at a time: a load step, then a multiply-accumulate over every tap and a drain
// step for an interior window; each result word is held until taken, and the block then
// returns to idle before the next accept (a word with no result goes back from the load)
// arst_n clears counters and control and sets config to its defaults; line buffers and window hold no reset
// pixel_stall is high from accept until the last result word is taken (to the end of the load if none);
// result_stall holds the result word in place
`default_nettype none

module window_blur_filter_core import wbf_pkg::*; #(
	parameter int MAX_WIDTH  = MaxWidthDef,
	parameter int MAX_RADIUS = MaxRadiusDef,
	parameter int COEF_BITS  = CoefBitsDef
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                pixel_valid,
	output logic                     pixel_stall,
	input  wire logic [PixW-1:0]     pixel_value,
	output logic                     result_valid,
	input  wire logic                result_stall,
	output logic      [OutXW-1:0]    out_x,
	output logic      [OutYW-1:0]    out_y,
	output logic      [PixW-1:0]     out_value,
	output logic                     last_of_item,
	input  wire logic                cfg_we,
	input  wire logic [CfgIdxW-1:0]  cfg_index,
	input  wire logic [CfgDataW-1:0] cfg_data
);

	localparam int WIN   = 2 * MAX_RADIUS + 1;
	localparam int LINES = 2 * MAX_RADIUS;
	localparam int XW    = $clog2(MAX_WIDTH);
	localparam int IW    = $clog2(WIN);
	localparam int DW13  = 13;
	localparam int ACC_W = COEF_BITS + PixW + 6;
	localparam int PRD_W = COEF_BITS + PixW;

	typedef enum logic [2:0] {
		ST_IDLE, ST_LOAD, ST_MUL, ST_DRAIN, ST_EMIT_B, ST_HOLD_B, ST_HOLD_P
	} state_t;

	state_t state_q;

	// config registers
	logic              mode_q;
	logic [1:0]        radius_q;
	logic [10:0]       width_q;
	logic [12:0]       height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= 1'b0;
			radius_q <= 2'd1;
			width_q  <= 11'd1024;
			height_q <= 13'd1024;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BLUR_MODE:     mode_q   <= cfg_data[0];
				REG_KERNEL_RADIUS: radius_q <= cfg_data[1:0];
				REG_IMAGE_WIDTH:   width_q  <= cfg_data[10:0];
				REG_IMAGE_HEIGHT:  height_q <= cfg_data[12:0];
				default: ;
			endcase
		end
	end

	// clamped radius, width, height
	logic [IW-1:0]   r_c;
	logic [DW13-1:0] w_c;
	logic [DW13-1:0] h_c;

	always_comb begin
		r_c = (radius_q == 2'd0) ? IW'(1) : IW'(radius_q);
		if (int'(r_c) > MAX_RADIUS) r_c = IW'(MAX_RADIUS);
		if (int'(r_c) > RomRadii)   r_c = IW'(RomRadii);
		w_c = (width_q == 11'd0) ? DW13'(1) : DW13'(width_q);
		if (int'(w_c) > MAX_WIDTH) w_c = DW13'(MAX_WIDTH);
		h_c = (height_q == 13'd0) ? DW13'(1) : height_q;
		if (int'(h_c) > FrameRowsMax) h_c = DW13'(FrameRowsMax);
	end

	// raster position of the next word
	logic [XW-1:0]    x_q;
	logic [OutYW-1:0] y_q;
	logic             accept;
	logic [DW13-1:0]  xe;
	logic [DW13-1:0]  ye;
	logic [DW13-1:0]  re;
	logic [DW13-1:0]  r2e;
	logic             blur_c;
	logic             pass_c;

	assign accept = pixel_valid && !pixel_stall;
	assign xe     = DW13'(x_q);
	assign ye     = DW13'(y_q);
	assign re     = DW13'(r_c);
	assign r2e    = DW13'({r_c, 1'b0});
	assign blur_c = (xe >= r2e) && (ye >= r2e) && (xe < w_c) && (ye < h_c);
	assign pass_c = (xe < re) || (ye < re) || (xe + re >= w_c) || (ye + re >= h_c);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= '0;
			y_q <= '0;
		end else if (accept) begin
			if (xe + DW13'(1) >= w_c) begin
				x_q <= '0;
				y_q <= (ye + DW13'(1) >= h_c) ? '0 : y_q + OutYW'(1);
			end else begin
				x_q <= x_q + XW'(1);
			end
		end
	end

	// word under work
	logic [PixW-1:0]  pix_q;
	logic [XW-1:0]    xa_q;
	logic [OutYW-1:0] ya_q;
	logic [IW-1:0]    r_q;
	logic             blur_q;
	logic             pass_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_q  <= pixel_value;
			xa_q   <= x_q;
			ya_q   <= y_q;
			r_q    <= r_c;
			blur_q <= blur_c;
			pass_q <= pass_c;
		end
	end

	// line buffers, read at accept, shifted down one line in the load cycle
	logic [PixW-1:0] line_rd [LINES];
	logic [IW:0]     r2_q;

	assign r2_q = {r_q, 1'b0};

	for (genvar k = 0; k < LINES; k++) begin : g_line
		logic [PixW-1:0] wd;
		logic            we;
		if (k == 0) begin : g_first
			assign wd = pix_q;
		end else begin : g_rest
			assign wd = line_rd[k-1];
		end
		assign we = (state_q == ST_LOAD) && (k < int'(r2_q));
		wbf_ram #(.DW(PixW), .DEPTH(MAX_WIDTH)) u_line (
			.clk   (clk),
			.we    (we),
			.waddr (xa_q),
			.wdata (wd),
			.raddr (x_q),
			.rdata (line_rd[k])
		);
	end

	// new window column: rows y-2R..y at column x
	logic [PixW-1:0] new_col [WIN];
	logic [WIN-1:0]  row_en;

	always_comb begin
		for (int j = 0; j < WIN; j++) begin
			new_col[j] = pix_q;
			row_en[j]  = (j <= int'(r2_q));
			for (int k = 0; k < LINES; k++) begin
				if ((j < int'(r2_q)) && (k == int'(r2_q) - 1 - j)) begin
					new_col[j] = line_rd[k];
				end
			end
		end
	end

	// chain of column cells, cell i takes cell i+1 each load for i below 2R, cell 2R takes the new column
	logic [PixW-1:0] cell_col [WIN][WIN];
	logic [PixW-1:0] cell_pix [WIN];
	logic [IW-1:0]   mi_q;
	logic [IW-1:0]   mj_q;

	for (genvar i = 0; i < WIN; i++) begin : g_cell
		cell_ctrl_t ctrl;
		assign ctrl = '{
			shift:    (state_q == ST_LOAD),
			take_new: (i == int'(r2_q)),
			take_nb:  (i < int'(r2_q))
		};
		wbf_col_cell #(.WIN(WIN)) u_cell (
			.clk     (clk),
			.ctrl    (ctrl),
			.row_en  (row_en),
			.nb_col  (cell_col[(i == WIN - 1) ? i : i + 1]),
			.new_col (new_col),
			.sel     (mj_q),
			.col_q   (cell_col[i]),
			.sel_pix (cell_pix[i])
		);
	end

	// coefficient rom, built at elaboration; box weight is the same for every tap
	logic [COEF_BITS-1:0] box_tab [RomRadii];
	logic [COEF_BITS-1:0] gauss_tab [RomRadii][RomSide][RomSide];

	for (genvar gr = 0; gr < RomRadii; gr++) begin : g_rr
		assign box_tab[gr] = COEF_BITS'(coef_f(0, gr + 1, 0, COEF_BITS));
		for (genvar gi = 0; gi < RomSide; gi++) begin : g_ri
			for (genvar gj = 0; gj < RomSide; gj++) begin : g_rj
				assign gauss_tab[gr][gi][gj] =
					COEF_BITS'(coef_f(1, gr + 1, gi * RomSide + gj, COEF_BITS));
			end
		end
	end

	// multiply-accumulate, one tap per cycle
	logic [COEF_BITS-1:0] coef_sel;
	logic [PRD_W-1:0]     prod_s1;
	logic                 pv_s1;
	logic [ACC_W-1:0]     acc_q;
	logic [ACC_W-1:0]     acc_shr;
	logic [PixW-1:0]      blur_val;

	assign coef_sel = mode_q ? gauss_tab[2'(r_q - IW'(1))][3'(mi_q)][3'(mj_q)]
		: box_tab[2'(r_q - IW'(1))];
	assign acc_shr  = acc_q >> COEF_BITS;
	assign blur_val = (acc_shr > ACC_W'(16'hffff)) ? 16'hffff : acc_shr[PixW-1:0];

	always_ff @(posedge clk) begin
		prod_s1 <= PRD_W'(cell_pix[mi_q]) * PRD_W'(coef_sel);
		if (state_q == ST_LOAD) begin
			acc_q <= '0;
		end else if (pv_s1) begin
			acc_q <= acc_q + ACC_W'(prod_s1);
		end
	end

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			pixel_stall  <= 1'b0;
			result_valid <= 1'b0;
			pv_s1        <= 1'b0;
			mi_q         <= '0;
			mj_q         <= '0;
			out_x        <= '0;
			out_y        <= '0;
			out_value    <= '0;
			last_of_item <= 1'b0;
		end else begin
			pv_s1 <= (state_q == ST_MUL);
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q     <= ST_LOAD;
						pixel_stall <= 1'b1;
					end
				end
				ST_LOAD: begin
					mi_q <= '0;
					mj_q <= '0;
					if (blur_q) begin
						state_q <= ST_MUL;
					end else if (pass_q) begin
						out_x        <= OutXW'(xa_q);
						out_y        <= ya_q;
						out_value    <= pix_q;
						last_of_item <= 1'b1;
						result_valid <= 1'b1;
						state_q      <= ST_HOLD_P;
					end else begin
						pixel_stall <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				ST_MUL: begin
					if (mj_q == IW'(r2_q)) begin
						mj_q <= '0;
						if (mi_q == IW'(r2_q)) begin
							state_q <= ST_DRAIN;
						end else begin
							mi_q <= mi_q + IW'(1);
						end
					end else begin
						mj_q <= mj_q + IW'(1);
					end
				end
				ST_DRAIN: begin
					state_q <= ST_EMIT_B;
				end
				ST_EMIT_B: begin
					out_x        <= OutXW'(xa_q - XW'(r_q));
					out_y        <= ya_q - OutYW'(r_q);
					out_value    <= blur_val;
					last_of_item <= !pass_q;
					result_valid <= 1'b1;
					state_q      <= ST_HOLD_B;
				end
				ST_HOLD_B: begin
					if (!result_stall) begin
						if (pass_q) begin
							out_x        <= OutXW'(xa_q);
							out_y        <= ya_q;
							out_value    <= pix_q;
							last_of_item <= 1'b1;
							state_q      <= ST_HOLD_P;
						end else begin
							result_valid <= 1'b0;
							pixel_stall  <= 1'b0;
							state_q      <= ST_IDLE;
						end
					end
				end
				ST_HOLD_P: begin
					if (!result_stall) begin
						result_valid <= 1'b0;
						pixel_stall  <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- hdl/wbf_checker.sv -----
`default_nettype none

module wbf_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        pixel_valid,
	input wire logic        pixel_stall,
	input wire logic        result_valid,
	input wire logic        result_stall,
	input wire logic [9:0]  out_x,
	input wire logic [11:0] out_y,
	input wire logic [15:0] out_value,
	input wire logic        last_of_item
);

	// a stalled result word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(out_value)
			&& $stable(out_x) && $stable(out_y))
		else $error("result word changed under stall");

	// busy right after an accepted pixel
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_valid && !pixel_stall |=> pixel_stall)
		else $error("pixel accepted while previous word in work");

	// no pixel taken while a result is pending
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> pixel_stall)
		else $error("input open while result pending");

	// the second result of a word follows the first at once
	a_pair: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_stall && !last_of_item |=> result_valid && last_of_item)
		else $error("second result word missing");

endmodule

bind window_blur_filter_core wbf_checker u_wbf_checker (.*);

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
	import wbf_pkg::*;

	typedef struct packed {
		logic [OutXW-1:0] x;
		logic [OutYW-1:0] y;
		logic [PixW-1:0]  value;
		logic             last;
	} blur_word_t;

	// clock, reset and block ports
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic pixel_valid = 1'b0;
	logic pixel_stall;
	logic [PixW-1:0] pixel_value = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	logic [OutXW-1:0] out_x;
	logic [OutYW-1:0] out_y;
	logic [PixW-1:0] out_value;
	logic last_of_item;
	logic cfg_we = 1'b0;
	logic [CfgIdxW-1:0] cfg_index = REG_BLUR_MODE;
	logic [CfgDataW-1:0] cfg_data = '0;

	window_blur_filter_core DUT (
		.clk(clk), .arst_n(arst_n),
		.pixel_valid(pixel_valid), .pixel_stall(pixel_stall), .pixel_value(pixel_value),
		.result_valid(result_valid), .result_stall(result_stall),
		.out_x(out_x), .out_y(out_y), .out_value(out_value), .last_of_item(last_of_item),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// predictor state: own copy of registers, line buffers, window and counters
	logic [31:0] kern_coef [2][RomRadii][RomSide*RomSide];
	int unsigned mode_q, radius_q, width_q, height_q;
	logic [PixW-1:0] line_buf [2*MaxRadiusDef][MaxWidthDef];
	logic [PixW-1:0] win [RomSide][RomSide];
	int unsigned col_q, row_q;

	logic [PixW-1:0] pixels_to_send [$];
	blur_word_t blurred_words_due [$];
	int errors = 0;
	bit hold_off_req = 0;

	// coefficients built independently from exp(-1/R) in Q0.32
	function automatic void build_kernels();
		logic [63:0] wt [RomSide*RomSide];
		logic [63:0] p, sum, n, g;
		int side, d;
		for (int r = 1; r <= RomRadii; r++) begin
			side = 2 * r + 1;
			n = side * side;
			g = GaussStepQ32[r-1];
			sum = 0;
			for (int i = 0; i < side; i++)
				for (int j = 0; j < side; j++) begin
					d = (i - r) * (i - r) + (j - r) * (j - r);
					p = 64'd1 << 32;
					repeat (d) p = (p * g + (64'd1 << 31)) >> 32;
					wt[i*RomSide+j] = p;
					sum += p;
				end
			for (int k = 0; k < RomSide * RomSide; k++) begin
				kern_coef[0][r-1][k] = ((64'd1 << CoefBitsDef) + n / 2) / n;
				kern_coef[1][r-1][k] = ((wt[k] << CoefBitsDef) + sum / 2) / sum;
			end
		end
	endfunction

	// one pixel through the predictor; expected words go on the queue
	function automatic void blur_pixel(logic [PixW-1:0] pix);
		int unsigned r, w, h, x, y, xi, side;
		logic [PixW-1:0] colv [RomSide];
		logic [63:0] acc;
		blur_word_t bw;
		int nres;
		r = (radius_q == 0) ? 1 : radius_q;
		if (r > RomRadii) r = RomRadii;
		w = (width_q == 0) ? 1 : (width_q > MaxWidthDef ? MaxWidthDef : width_q);
		h = (height_q == 0) ? 1 : (height_q > FrameRowsMax ? FrameRowsMax : height_q);
		side = 2 * r + 1;
		x = col_q;
		y = row_q;
		xi = x < MaxWidthDef ? x : MaxWidthDef - 1;
		colv[2*r] = pix;
		for (int k = 0; k < 2 * r; k++) colv[2*r-1-k] = line_buf[k][xi];
		for (int k = 2 * r - 1; k > 0; k--) line_buf[k][xi] = line_buf[k-1][xi];
		line_buf[0][xi] = pix;
		for (int j = 0; j < side; j++) begin
			for (int i = 0; i + 1 < side; i++) win[j][i] = win[j][i+1];
			win[j][2*r] = colv[j];
		end
		nres = 0;
		if (x >= 2 * r && y >= 2 * r && x < w && y < h) begin
			acc = 0;
			for (int j = 0; j < side; j++)
				for (int i = 0; i < side; i++)
					acc += kern_coef[mode_q][r-1][i*RomSide+j] * win[j][i];
			acc = acc >> CoefBitsDef;
			bw.x = x - r;
			bw.y = y - r;
			bw.value = acc > 65535 ? 16'hFFFF : acc[15:0];
			bw.last = 1'b1;
			blurred_words_due.push_back(bw);
			nres++;
		end
		if (x < r || y < r || x + r >= w || y + r >= h) begin
			// border pixel passes through; it is then the last word
			if (nres > 0) blurred_words_due[$].last = 1'b0;
			bw.x = x;
			bw.y = y;
			bw.value = pix;
			bw.last = 1'b1;
			blurred_words_due.push_back(bw);
		end
		if (x + 1 >= w) begin
			col_q = 0;
			row_q = (y + 1 >= h) ? 0 : y + 1;
		end else begin
			col_q = x + 1;
		end
	endfunction

	// random pixel: extremes often so every bit toggles both ways
	function automatic logic [PixW-1:0] rand_pixel();
		case ($urandom_range(0, 5))
			0: return 16'hFFFF;
			1: return 16'h0000;
			2: return 16'(65535 - $urandom_range(0, 300));
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic write_reg(cfg_reg_t idx, int unsigned val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CfgDataW'(val);
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_BLUR_MODE:     mode_q = val & 1;
			REG_KERNEL_RADIUS: radius_q = val & 3;
			REG_IMAGE_WIDTH:   width_q = val & 11'h7FF;
			REG_IMAGE_HEIGHT:  height_q = val & 13'h1FFF;
			default: ;
		endcase
	endtask

	// one whole frame, queued for the driver, then drained before returning
	task automatic run_frame(int unsigned mode, int unsigned r, int unsigned w,
			int unsigned h, bit directed);
		logic [PixW-1:0] p;
		int unsigned n_pix;
		write_reg(REG_BLUR_MODE, mode);
		write_reg(REG_KERNEL_RADIUS, r);
		write_reg(REG_IMAGE_WIDTH, w);
		write_reg(REG_IMAGE_HEIGHT, h);
		// a zero size register counts as one
		n_pix = ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h);
		for (int k = 0; k < n_pix; k++) begin
			if (directed) p = (k % 3 == 0) ? 16'hFFFF : ((k % 3 == 1) ? 16'h0000 : 16'hA5A5);
			else p = rand_pixel();
			blur_pixel(p);
			pixels_to_send.push_back(p);
		end
		// drain: queue empty, no expectation, then block latency margin
		while (pixels_to_send.size() != 0 || blurred_words_due.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	// stall as seen at the rising edge, so the driver knows what was accepted
	logic pixel_stall_s = 1'b1;
	always @(posedge clk) pixel_stall_s <= pixel_stall;

	// driver: bursts of random length with random gaps, change at falling edge
	int burst_left = 0;
	int gap_left = 0;
	always @(negedge clk) begin
		if (arst_n) begin
			if (pixel_valid && !pixel_stall_s) begin
				// word taken at the last rising edge
				void'(pixels_to_send.pop_front());
			end
			if (pixel_valid && pixel_stall_s) begin
				// hold the offered word
			end else if (pixels_to_send.size() == 0) begin
				pixel_valid <= 1'b0;
			end else if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				pixel_valid <= 1'b0;
			end else begin
				pixel_valid <= 1'b1;
				pixel_value <= pixels_to_send[0];
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 20);
					gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
				end else begin
					burst_left <= burst_left - 1;
				end
			end
		end
	end

	// receiver stall pattern, plus one long hold-off counted here
	int stall_phase = 0;
	int hold_cnt = 0;
	always @(negedge clk) begin
		stall_phase <= stall_phase + 1;
		if (hold_off_req && hold_cnt == 0) begin
			hold_cnt <= 400;
			hold_off_req <= 1'b0;
			result_stall <= 1'b1;
		end else if (hold_cnt > 1) begin
			hold_cnt <= hold_cnt - 1;
			result_stall <= 1'b1;
		end else begin
			if (hold_cnt == 1) hold_cnt <= 0;
			// quiet stretches alternate with random stalling
			if ((stall_phase / 256) % 2 == 0) result_stall <= 1'b0;
			else result_stall <= ($urandom_range(0, 3) == 0);
		end
	end

	// monitor: compare each taken result word with the oldest expectation
	always @(posedge clk) begin
		blur_word_t exp_w;
		if (arst_n && result_valid && !result_stall) begin
			if (blurred_words_due.size() == 0) begin
				$display("%0t: unexpected word x=%0d y=%0d value=%0d last=%0b",
					$time, out_x, out_y, out_value, last_of_item);
				errors++;
			end else begin
				exp_w = blurred_words_due.pop_front();
				if (out_x !== exp_w.x || out_y !== exp_w.y || out_value !== exp_w.value ||
						last_of_item !== exp_w.last) begin
					$display("%0t: mismatch expected x=%0d y=%0d value=%0d last=%0b",
						$time, exp_w.x, exp_w.y, exp_w.value, exp_w.last);
					$display("%0t:          actual   x=%0d y=%0d value=%0d last=%0b",
						$time, out_x, out_y, out_value, last_of_item);
					errors++;
				end
			end
		end
	end

	initial begin
		int total;
		build_kernels();
		mode_q = 0;
		radius_q = 1;
		width_q = 1024;
		height_q = 1024;
		col_q = 0;
		row_q = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: small frames, radii 1 and 3, both kernels, saturating pattern
		run_frame(0, 1, 1, 1, 1);
		run_frame(1, 3, 4, 3, 1);
		run_frame(1, 1, 3, 3, 1);
		// long hold-off while a frame streams in: the block fills and stalls input
		hold_off_req = 1'b1;
		run_frame(0, 2, 5, 5, 0);

		// random frames over all radii and kernels, small sizes, zero sizes too
		total = 0;
		while (total < 600) begin
			int unsigned m, r, w, h;
			m = $urandom_range(0, 1);
			r = $urandom_range(0, 3);
			w = $urandom_range(0, 12);
			h = $urandom_range(0, 10);
			run_frame(m, r, w, h, 0);
			total += ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h);
		end
		// largest kernel on a frame with a full interior
		run_frame(0, 3, 9, 8, 0);

		if (errors == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

	initial begin
		#3000000;
		$display("tb_top: FAIL");
		$finish;
	end

endmodule
